// ===== rtl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants for the countdown timer bank
// Command and result transaction layouts, timer state entry, command codes.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int IDX_W          = 4;

  // command codes (kind field); code 7 is undefined and rejected
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SCAN    = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_RESTART = 3'd3;
  localparam logic [2:0] KIND_STOP    = 3'd4;
  localparam logic [2:0] KIND_ADD     = 3'd5;
  localparam logic [2:0] KIND_QUERY   = 3'd6;

  localparam logic signed [31:0] COUNT_IDLE = -32'sd1;
  localparam logic signed [31:0] COUNT_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] COUNT_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         kind;
    logic [IDX_W-1:0]   timer_index;
    logic signed [31:0] amount;
    logic               notify;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] count_value;
    logic               expired_valid;
    logic [2:0]         expired_index;
    logic               expired_notify;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               active;
    logic               notify_mark;
    logic signed [31:0] remaining;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{active: 1'b0, notify_mark: 1'b0, remaining: COUNT_IDLE};

  // state memory access: one write port, one registered read port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/ctb_mem.sv =====
// ----------------------------------------------------------------------------
// ctb_mem: timer state memory
// One entry per timer, registered read: data follows the address in the next cycle. Entries
// not written since reset read as the idle state.
// ----------------------------------------------------------------------------
module ctb_mem #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctb_pkg::mem_req_t req,
  output ctb_pkg::entry_t   rdata
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  ctb_pkg::entry_t mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld;

  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  assign wa = req.waddr[AW-1:0];
  assign ra = req.raddr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[wa] <= req.wdata;
    end
    rdata <= vld[ra] ? mem[ra] : ctb_pkg::ENTRY_RESET;
  end

endmodule

// ===== rtl/countdown_timer_bank.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_bank: bank of countdown timers with command interface
// Timer state lives in a single memory; tick and scan walk every entry
// with a read-modify-write pipeline, other commands touch one entry.
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  --------  ----------------------------  -------------------------------
//  command   cmd (cmd_t)                   taken when start && !busy
//  result    result (result_t)             one-cycle strobe result_valid
//
// Tick and scan do one memory read per timer, each write-back overlapping
// the read of the next timer, then pass through the flush state. Start,
// restart, stop, add and query read, then modify and write. Each result is
// registered in the output register before it is shown; busy drops in the
// cycle that shows the last one.
// Reset clears the state machine and the memory valid bits; no clearing
// pass is needed. The receiver cannot stall: results are never held back.
//
module countdown_timer_bank #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ctb_pkg::cmd_t    cmd,
  output logic             result_valid,
  output ctb_pkg::result_t result
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int KW = $clog2(ctb_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_WALK,
    ST_FLUSH
  } state_t;

  state_t state;

  ctb_pkg::cmd_t     cmd_q;     // latched command transaction
  ctb_pkg::mem_req_t mreq;
  ctb_pkg::entry_t   rdata;

  logic [CW-1:0] rd_cnt;        // next timer to read during a walk
  logic [AW-1:0] pidx;          // timer whose data is in rdata
  logic [KW-1:0] kcnt;          // expiries found in this scan
  logic          hbuf;          // an expiry report is held back
  logic [2:0]    buf_idx;
  logic          buf_nfy;

  logic          accept;
  logic          walk_kind;
  logic          hit;           // scan: current timer has expired
  logic          cmd_ok;
  logic signed [31:0] cmd_cv;
  logic signed [32:0] add_sum;
  logic               idx_ok;

  ctb_mem #(.NUM_TIMERS(NUM_TIMERS)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign walk_kind = (cmd.kind == ctb_pkg::KIND_TICK) || (cmd.kind == ctb_pkg::KIND_SCAN);
  assign idx_ok    = ({1'b0, cmd_q.timer_index} < 5'(NUM_TIMERS));
  assign add_sum   = {rdata.remaining[31], rdata.remaining} + {cmd_q.amount[31], cmd_q.amount};

  // Memory request and per-cycle decisions. Reads and writes during a walk
  // address different timers, so no forwarding is needed.
  always_comb begin
    mreq       = '0;
    mreq.wdata = rdata;
    hit        = 1'b0;
    cmd_ok     = 1'b0;
    cmd_cv     = ctb_pkg::COUNT_IDLE;

    unique case (state)
      ST_IDLE: begin
        mreq.raddr = walk_kind ? '0 : cmd.timer_index;
      end
      ST_WALK: begin
        mreq.raddr = ctb_pkg::IDX_W'(rd_cnt[AW-1:0]);
        mreq.waddr = ctb_pkg::IDX_W'(pidx);
        if (cmd_q.kind == ctb_pkg::KIND_TICK) begin
          if (rdata.active && (rdata.remaining > 0)) begin
            mreq.we              = 1'b1;
            mreq.wdata.remaining = rdata.remaining - 32'sd1;
          end
        end else begin
          hit = rdata.active && (rdata.remaining == 0) &&
                (kcnt != KW'(ctb_pkg::MAX_RESULTS));
          if (hit) begin
            mreq.we    = 1'b1;
            mreq.wdata = ctb_pkg::ENTRY_RESET;
          end
        end
      end
      ST_CMD: begin
        mreq.waddr = cmd_q.timer_index;
        if (idx_ok) begin
          unique case (cmd_q.kind)
            ctb_pkg::KIND_START: begin
              if (!rdata.active) begin
                mreq.we    = 1'b1;
                mreq.wdata = '{active: 1'b1, notify_mark: cmd_q.notify,
                               remaining: cmd_q.amount};
                cmd_ok     = 1'b1;
                cmd_cv     = cmd_q.amount;
              end
            end
            ctb_pkg::KIND_RESTART: begin
              if (rdata.active) begin
                mreq.we              = 1'b1;
                mreq.wdata.remaining = cmd_q.amount;
                cmd_ok               = 1'b1;
                cmd_cv               = cmd_q.amount;
              end
            end
            ctb_pkg::KIND_STOP: begin
              if (rdata.active) begin
                mreq.we    = 1'b1;
                mreq.wdata = ctb_pkg::ENTRY_RESET;
                cmd_ok     = 1'b1;
              end
            end
            ctb_pkg::KIND_ADD: begin
              if (rdata.active) begin
                mreq.we = 1'b1;
                // saturate when the 33-bit sum leaves the 32-bit range
                if (add_sum[32] != add_sum[31]) begin
                  mreq.wdata.remaining = add_sum[32] ? ctb_pkg::COUNT_MIN
                                                     : ctb_pkg::COUNT_MAX;
                end else begin
                  mreq.wdata.remaining = add_sum[31:0];
                end
                cmd_ok = 1'b1;
                cmd_cv = mreq.wdata.remaining;
              end
            end
            ctb_pkg::KIND_QUERY: begin
              if (rdata.active) begin
                cmd_ok = 1'b1;
                cmd_cv = rdata.remaining;
              end
            end
            default: begin
              cmd_ok = 1'b0;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        mreq.raddr = '0;
      end
      default: begin
        mreq.raddr = '0;
      end
    endcase
  end

  // State, walk counters, held expiry report and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      rd_cnt       <= '0;
      pidx         <= '0;
      kcnt         <= '0;
      hbuf         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd;
            rd_cnt <= CW'(1);
            pidx   <= '0;
            kcnt   <= '0;
            hbuf   <= 1'b0;
            state  <= walk_kind ? ST_WALK : ST_CMD;
          end
        end
        ST_CMD: begin
          result_valid <= 1'b1;
          result       <= '{ok: cmd_ok, count_value: cmd_cv, expired_valid: 1'b0,
                            expired_index: 3'd0, expired_notify: 1'b0, last: 1'b1};
          state        <= ST_IDLE;
        end
        ST_WALK: begin
          if (hit) begin
            // a newer expiry proves the held one is not the last
            if (hbuf) begin
              result_valid <= 1'b1;
              result       <= '{ok: 1'b1, count_value: ctb_pkg::COUNT_IDLE,
                                expired_valid: 1'b1, expired_index: buf_idx,
                                expired_notify: buf_nfy, last: 1'b0};
            end
            hbuf    <= 1'b1;
            buf_idx <= 3'(pidx);
            buf_nfy <= rdata.notify_mark;
            kcnt    <= kcnt + 1'b1;
          end
          if (rd_cnt == CW'(NUM_TIMERS)) begin
            state <= ST_FLUSH;
          end else begin
            pidx   <= rd_cnt[AW-1:0];
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        ST_FLUSH: begin
          result_valid <= 1'b1;
          if (hbuf) begin
            result <= '{ok: 1'b1, count_value: ctb_pkg::COUNT_IDLE,
                        expired_valid: 1'b1, expired_index: buf_idx,
                        expired_notify: buf_nfy, last: 1'b1};
          end else begin
            result <= '{ok: 1'b1, count_value: ctb_pkg::COUNT_IDLE,
                        expired_valid: 1'b0, expired_index: 3'd0,
                        expired_notify: 1'b0, last: 1'b1};
          end
          hbuf  <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the closing result of a transaction coincides with the return to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("last result shown while still busy");

  // an accepted command always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  // no memory write outside command or walk processing
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) || (state == ST_FLUSH) |-> !mreq.we)
    else $error("state memory written while idle or flushing");

  // expiry reports are always accepted results
  a_expired_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.expired_valid |-> result.ok)
    else $error("expiry report with ok low");

  // a scan never clears more timers than it can report
  a_scan_limit: assert property (@(posedge clk) disable iff (rst)
    hit |-> (kcnt < KW'(ctb_pkg::MAX_RESULTS)))
    else $error("scan exceeded the report limit");
`endif

endmodule

// ===== bench/countdown_timer_bank_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// countdown_timer_bank_tb: self-checking bench for the countdown timer bank
// Drives command transactions through the start/busy handshake, mirrors the
// timer bank state in a scoreboard class and checks every result strobe.
// ----------------------------------------------------------------------------
module countdown_timer_bank_tb;

  localparam int         BANK         = ctb_pkg::NUM_TIMERS_DEF;
  localparam logic [2:0] KIND_UNDEF   = 3'd7;     // undefined code, rejected
  localparam int         CYCLE_LIMIT  = 60000;    // watchdog limit on the run length
  localparam int         REPORT_LIMIT = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the timer bank plus the results still owed.
  // --------------------------------------------------------------------------
  class timer_bank_mirror;
    bit                 armed[BANK];
    logic signed [31:0] left[BANK];
    bit                 wants_note[BANK];
    ctb_pkg::result_t   due[$];
    int                 failures;

    function void clear();
      for (int n = 0; n < BANK; n++) begin
        armed[n]      = 1'b0;
        left[n]       = ctb_pkg::COUNT_IDLE;
        wants_note[n] = 1'b0;
      end
      due.delete();
      failures = 0;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    function void owe(bit ok, logic signed [31:0] cv, bit ev, logic [2:0] idx,
                      bit en, bit fin);
      ctb_pkg::result_t r;
      r.ok             = ok;
      r.count_value    = cv;
      r.expired_valid  = ev;
      r.expired_index  = idx;
      r.expired_notify = en;
      r.last           = fin;
      due.push_back(r);
    endfunction

    // update the shadow bank for one accepted command, queue what it yields
    function void apply_command(ctb_pkg::cmd_t c);
      int                 hits;
      int                 t;
      bit                 in_bank;
      bit                 ok;
      logic signed [31:0] cv;
      longint             sum;
      ctb_pkg::result_t   tail;
      in_bank = c.timer_index < BANK;
      t       = c.timer_index;
      ok      = 1'b0;
      cv      = ctb_pkg::COUNT_IDLE;
      hits    = 0;
      case (c.kind)
        ctb_pkg::KIND_TICK: begin
          for (int n = 0; n < BANK; n++)
            if (armed[n] && left[n] > 0) left[n] = left[n] - 1;
          owe(1'b1, ctb_pkg::COUNT_IDLE, 1'b0, 3'd0, 1'b0, 1'b1);
        end
        ctb_pkg::KIND_SCAN: begin
          for (int n = 0; n < BANK && hits < ctb_pkg::MAX_RESULTS; n++) begin
            if (armed[n] && left[n] == 0) begin
              owe(1'b1, ctb_pkg::COUNT_IDLE, 1'b1, 3'(n), wants_note[n], 1'b0);
              armed[n] = 1'b0;
              left[n]  = ctb_pkg::COUNT_IDLE;
              hits++;
            end
          end
          if (hits == 0) begin
            owe(1'b1, ctb_pkg::COUNT_IDLE, 1'b0, 3'd0, 1'b0, 1'b1);
          end else begin
            tail      = due.pop_back();
            tail.last = 1'b1;
            due.push_back(tail);
          end
        end
        default: begin
          if (in_bank) begin
            case (c.kind)
              ctb_pkg::KIND_START: begin
                if (!armed[t]) begin
                  armed[t]      = 1'b1;
                  left[t]       = c.amount;
                  wants_note[t] = c.notify;
                  ok            = 1'b1;
                  cv            = c.amount;
                end
              end
              ctb_pkg::KIND_RESTART: begin
                if (armed[t]) begin
                  left[t] = c.amount;
                  ok      = 1'b1;
                  cv      = c.amount;
                end
              end
              ctb_pkg::KIND_STOP: begin
                if (armed[t]) begin
                  armed[t]      = 1'b0;
                  left[t]       = ctb_pkg::COUNT_IDLE;
                  wants_note[t] = 1'b0;
                  ok            = 1'b1;
                end
              end
              ctb_pkg::KIND_ADD: begin
                if (armed[t]) begin
                  sum = longint'(left[t]) + longint'($signed(c.amount));
                  if (sum > longint'(ctb_pkg::COUNT_MAX))
                    sum = longint'(ctb_pkg::COUNT_MAX);
                  else if (sum < longint'(ctb_pkg::COUNT_MIN))
                    sum = longint'(ctb_pkg::COUNT_MIN);
                  left[t] = sum[31:0];
                  ok      = 1'b1;
                  cv      = sum[31:0];
                end
              end
              ctb_pkg::KIND_QUERY: begin
                if (armed[t]) begin
                  ok = 1'b1;
                  cv = left[t];
                end
              end
              default: ;
            endcase
          end
          owe(ok, cv, 1'b0, 3'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void match_result(ctb_pkg::result_t got);
      ctb_pkg::result_t want;
      bit               bad;
      if (due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display({"mismatch: result with nothing owed: ",
                    "ok=%0b count=%0d ev=%0b idx=%0d en=%0b last=%0b"},
                   got.ok, got.count_value, got.expired_valid, got.expired_index,
                   got.expired_notify, got.last);
        return;
      end
      want = due.pop_front();
      bad  = (got.ok !== want.ok) || (got.count_value !== want.count_value) ||
             (got.expired_valid !== want.expired_valid) ||
             (got.expired_index !== want.expired_index) ||
             (got.expired_notify !== want.expired_notify) || (got.last !== want.last);
      if (bad) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("mismatch at %0t: expected ok=%0b count=%0d ev=%0b idx=%0d en=%0b last=%0b",
                   $realtime, want.ok, want.count_value, want.expired_valid,
                   want.expired_index, want.expired_notify, want.last);
          $display("              actual   ok=%0b count=%0d ev=%0b idx=%0d en=%0b last=%0b",
                   got.ok, got.count_value, got.expired_valid, got.expired_index,
                   got.expired_notify, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  ctb_pkg::cmd_t    cmd;
  logic             result_valid;
  ctb_pkg::result_t result;

  timer_bank_mirror board;
  int cycle_count = 0;

  countdown_timer_bank u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost result ends up here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("countdown_timer_bank_tb: FAIL");
    $finish;
  end

  // results cannot be held off, so every strobe is taken at the closing edge
  always @(posedge clk) begin
    if (!rst && result_valid) board.match_result(result);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic ctb_pkg::cmd_t make_cmd(logic [2:0] kind, logic [3:0] idx,
                                             logic signed [31:0] amt, logic nfy);
    ctb_pkg::cmd_t c;
    c.kind        = kind;
    c.timer_index = idx;
    c.amount      = amt;
    c.notify      = nfy;
    return c;
  endfunction

  // Mix is biased toward starting short timers and ticking/scanning them,
  // so expiries, reloads and saturating adds all happen regularly.
  function automatic ctb_pkg::cmd_t pick_command();
    ctb_pkg::cmd_t c;
    int            roll;
    roll = $urandom_range(99, 0);
    if (roll < 24)      c.kind = ctb_pkg::KIND_TICK;
    else if (roll < 38) c.kind = ctb_pkg::KIND_SCAN;
    else if (roll < 56) c.kind = ctb_pkg::KIND_START;
    else if (roll < 64) c.kind = ctb_pkg::KIND_RESTART;
    else if (roll < 72) c.kind = ctb_pkg::KIND_STOP;
    else if (roll < 82) c.kind = ctb_pkg::KIND_ADD;
    else if (roll < 96) c.kind = ctb_pkg::KIND_QUERY;
    else                c.kind = KIND_UNDEF;
    // mostly inside the bank; the upper indexes exercise rejection
    if ($urandom_range(99, 0) < 88) c.timer_index = 4'($urandom_range(BANK - 1, 0));
    else                            c.timer_index = 4'($urandom_range(15, BANK));
    c.notify = 1'($urandom_range(1, 0));
    c.amount = $urandom;
    roll     = $urandom_range(99, 0);
    if (c.kind == ctb_pkg::KIND_START || c.kind == ctb_pkg::KIND_RESTART) begin
      if (roll < 70)      c.amount = $urandom_range(6, 0);
      else if (roll < 80) c.amount = 32'sd0 - $urandom_range(3, 1);  // never expires
    end else if (c.kind == ctb_pkg::KIND_ADD) begin
      if (roll < 60)      c.amount = $urandom_range(6, 0) - 3;
      else if (roll < 70) c.amount = ctb_pkg::COUNT_MAX;
      else if (roll < 80) c.amount = ctb_pkg::COUNT_MIN;
    end
    return c;
  endfunction

  // present one transaction from the falling edge, hold until taken
  task automatic issue(input ctb_pkg::cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.apply_command(c);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // pause the sender until the bank has delivered everything owed
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int idle_pct);
    repeat (count) begin
      if ($urandom_range(99, 0) < idle_pct) hold_off($urandom_range(6, 1));
      issue(pick_command());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    board = new();
    board.clear();
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: rejections, saturation, expiry with and without notify
    issue(make_cmd(ctb_pkg::KIND_QUERY,   4'd0, 32'sd0, 1'b0));  // idle timer query
    issue(make_cmd(ctb_pkg::KIND_START,   4'd0, 32'sd2, 1'b1));
    issue(make_cmd(ctb_pkg::KIND_START,   4'd0, 32'sd9, 1'b0));  // already running
    issue(make_cmd(ctb_pkg::KIND_START,   4'd8, 32'sd1, 1'b1));  // outside the bank
    issue(make_cmd(ctb_pkg::KIND_RESTART, 4'd1, 32'sd3, 1'b0));  // idle restart
    issue(make_cmd(ctb_pkg::KIND_ADD,     4'd0, ctb_pkg::COUNT_MAX, 1'b0)); // clamps high
    issue(make_cmd(ctb_pkg::KIND_RESTART, 4'd0, 32'sd1, 1'b0));  // notify kept
    issue(make_cmd(ctb_pkg::KIND_TICK,    4'd15, 32'shffff_ffff, 1'b1));
    issue(make_cmd(ctb_pkg::KIND_SCAN,    4'd0, 32'sd0, 1'b0));  // timer 0 expires
    issue(make_cmd(ctb_pkg::KIND_SCAN,    4'd0, 32'sd0, 1'b0));  // nothing left
    issue(make_cmd(ctb_pkg::KIND_START,   4'd3, -32'sd5, 1'b1)); // negative: never expires
    issue(make_cmd(ctb_pkg::KIND_ADD,     4'd3, ctb_pkg::COUNT_MIN, 1'b0)); // clamps low
    issue(make_cmd(ctb_pkg::KIND_QUERY,   4'd3, 32'sd0, 1'b0));
    issue(make_cmd(ctb_pkg::KIND_STOP,    4'd3, 32'sd0, 1'b0));
    issue(make_cmd(ctb_pkg::KIND_STOP,    4'd3, 32'sd0, 1'b0));  // already idle
    issue(make_cmd(KIND_UNDEF,            4'd2, 32'sd7, 1'b1));
    // whole bank expires at once: the widest scan burst
    for (int i = 0; i < BANK; i++)
      issue(make_cmd(ctb_pkg::KIND_START, 4'(i), 32'sd0, 1'(i)));
    issue(make_cmd(ctb_pkg::KIND_SCAN,    4'd0, 32'sd0, 1'b0));
    issue(make_cmd(ctb_pkg::KIND_TICK,    4'd0, 32'sd0, 1'b0));
    drain();

    // random: light sender gaps, heavy gaps, then back to back
    random_phase(48, 16);
    drain();
    random_phase(48, 47);
    drain();
    random_phase(48, 0);
    drain();
    repeat (20) @(posedge clk);

    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("countdown_timer_bank_tb: PASS");
    end else begin
      if (board.outstanding() != 0)
        $display("%0d expected results never arrived", board.outstanding());
      $display("countdown_timer_bank_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== countdown_timer_bank.f =====
rtl/ctb_pkg.sv
rtl/ctb_mem.sv
rtl/countdown_timer_bank.sv
bench/countdown_timer_bank_tb.sv
